/* hdl/cbq_pkg.sv */
// Types, codes and saturation helpers shared by the cascaded biquad filter.
package cbq_pkg;

    localparam int NCOEF = 5;

    localparam logic [1:0] FUNC_FILTER = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic signed [63:0] D_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] D_MIN = 64'shFFFF_8000_0000_0000;
    localparam logic signed [63:0] S_MAX = 64'sh0000_0000_007F_FFFF;
    localparam logic signed [63:0] S_MIN = 64'shFFFF_FFFF_FF80_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Coefficient kinds; the first five codes are also the coefficient slot.
    typedef enum logic [2:0] {
        KIND_B0  = 3'd0,
        KIND_B1  = 3'd1,
        KIND_B2  = 3'd2,
        KIND_A1  = 3'd3,
        KIND_A2  = 3'd4,
        KIND_NOP = 3'd5
    } kind_t;

    function automatic logic ovf48(input logic signed [63:0] v);
        ovf48 = (v > D_MAX) || (v < D_MIN);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > D_MAX) begin
            sat48 = D_MAX[47:0];
        end else if (v < D_MIN) begin
            sat48 = D_MIN[47:0];
        end else begin
            sat48 = v[47:0];
        end
    endfunction

    function automatic logic ovf24(input logic signed [63:0] v);
        ovf24 = (v > S_MAX) || (v < S_MIN);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > S_MAX) begin
            sat24 = S_MAX[23:0];
        end else if (v < S_MIN) begin
            sat24 = S_MIN[23:0];
        end else begin
            sat24 = v[23:0];
        end
    endfunction

endpackage

/* hdl/cascaded_biquad_iir_filter_unit.sv */
// Cascaded biquad IIR filter, transposed direct form II, with memory-held state.
//
// The input channel (s_) carries one beat per command: s_tuser holds func, and
// s_tdata holds the sample for a filter beat or the stage, slot and value for a
// coefficient load. A clear beat zeroes every delay register. Load, clear and
// unused codes produce no output beat and leave the block idle.
// A filter beat produces one output beat on the m_ channel: m_tdata is the
// filtered sample and m_tuser flags that some section saturated.
// With no active sections the sample is output unchanged. No beat is accepted
// while a filter beat is in progress; the next is accepted in the cycle after
// the result is loaded. Each section issues its five coefficients, one per cycle
// from the coefficient memory, to the single shared 32x24 multiplier, plus one
// idle step while the section output is rounded. Delay registers live in a
// second memory that is read and written back once per section.
// The result sits in an output register, so a new beat is accepted while the
// previous result waits; a filter beat cannot complete until that register is
// free, and the block holds its result while m_tready is low.
// After reset num_stages is zero and all coefficients and delays read as zero.
// cfg_we writes num_stages; it must only be used while the block is idle.
module cascaded_biquad_iir_filter_unit
    import cbq_pkg::*;
#(
    parameter int STAGES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample[23:0], stage_index[25:24], coef_index[28:26], coef_value[60:29]
    input  logic [63:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // filtered[23:0]
    output logic [23:0] m_tdata,
    // clipped[0]
    output logic [0:0]  m_tuser
);

    localparam int SEC_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CDEPTH = NCOEF * STAGES;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int DDEPTH = 2 * STAGES;
    localparam int DA_W   = $clog2(DDEPTH);
    localparam int N_W    = $clog2(STAGES + 1);

    state_t state_reg, state_next;

    logic [2:0] num_stages_reg;

    logic [31:0] coef_mem [CDEPTH];
    logic [47:0] dly_mem  [DDEPTH];
    logic [CDEPTH-1:0] coef_vld_reg;
    logic [DDEPTH-1:0] dly_vld_reg;

    logic [31:0] coef_q;
    logic        coef_vq;
    logic signed [47:0] dly_q;
    logic        dly_vq;

    logic [SEC_W-1:0] sec_reg;
    logic [2:0]       stp_reg;
    logic             iss_done_reg;

    kind_t            tag1_kind, tag2_kind, tag3_kind;
    logic [SEC_W-1:0] tag1_sec, tag2_sec, tag3_sec;
    logic             tag1_last, tag2_last, tag3_last;

    logic signed [23:0] x_reg, y_reg;
    logic signed [55:0] prod_reg;
    logic signed [47:0] pr_reg;
    logic               pr_ovf_reg;
    logic signed [47:0] yf_reg;
    logic signed [49:0] n1_reg, n2_reg;
    logic               ystep_reg;
    logic               clip_reg;

    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    logic               m_tuser_reg;

    logic [1:0]         in_func;
    logic signed [23:0] in_sample;
    logic [1:0]         in_stage;
    logic [2:0]         in_cidx;
    logic [31:0]        in_cval;

    logic               s_tready_w;
    logic               in_acc;
    logic               out_load;
    logic               iss_act;
    logic [N_W-1:0]     n_eff;
    logic [N_W-1:0]     last_sec;
    logic               sec_last;
    kind_t              iss_kind;
    logic [2:0]         iss_ofs;
    logic [CA_W-1:0]    coef_raddr;
    logic [CA_W-1:0]    coef_waddr;
    logic               coef_we;
    logic [DA_W-1:0]    dly_raddr;
    logic [DA_W-1:0]    dly_waddr;
    logic               dly_we;
    logic signed [47:0] dly_wdata;

    logic signed [23:0] opnd;
    logic signed [31:0] coef_eff;
    logic signed [63:0] rnd_sum;
    logic signed [63:0] rnd_shift;
    logic signed [47:0] zq_eff;
    logic signed [63:0] sum_b0;
    logic signed [63:0] sum_a;
    logic signed [63:0] ysum;
    logic               clip_ev;

    assign in_func   = s_tuser;
    assign in_sample = s_tdata[23:0];
    assign in_stage  = s_tdata[25:24];
    assign in_cidx   = s_tdata[28:26];
    assign in_cval   = s_tdata[60:29];

    assign n_eff    = (32'(num_stages_reg) > STAGES) ? N_W'(STAGES) : N_W'(num_stages_reg);
    assign last_sec = n_eff - N_W'(1);
    assign sec_last = (N_W'(sec_reg) == last_sec);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_func == FUNC_FILTER) begin
                    state_next = (n_eff == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (tag3_kind == KIND_A2 && tag3_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready_w = 1'b0;
        out_load   = 1'b0;
        iss_act    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready_w = 1'b1;
            ST_RUN:  iss_act = !iss_done_reg;
            ST_DONE: out_load = !m_tvalid_reg || m_tready;
            default: s_tready_w = 1'b0;
        endcase
    end

    assign in_acc = s_tvalid && s_tready_w;

    always_comb begin
        unique case (stp_reg)
            3'd0:    iss_kind = KIND_B0;
            3'd1:    iss_kind = KIND_B1;
            3'd2:    iss_kind = KIND_B2;
            3'd4:    iss_kind = KIND_A1;
            3'd5:    iss_kind = KIND_A2;
            default: iss_kind = KIND_NOP;
        endcase
    end

    assign iss_ofs    = (iss_kind == KIND_NOP) ? 3'd0 : 3'(iss_kind);
    assign coef_raddr = CA_W'(CA_W'(sec_reg) * CA_W'(NCOEF) + CA_W'(iss_ofs));
    assign coef_waddr = CA_W'(CA_W'(in_stage) * CA_W'(NCOEF) + CA_W'(in_cidx));
    assign coef_we    = in_acc && in_func == FUNC_LOAD
                        && 32'(in_stage) < STAGES && 32'(in_cidx) < NCOEF;

    assign dly_raddr = DA_W'({tag2_sec, tag2_kind == KIND_B1});
    assign dly_waddr = DA_W'({tag3_sec, tag3_kind == KIND_A2});
    assign dly_we    = (tag3_kind == KIND_A1) || (tag3_kind == KIND_A2);

    assign opnd      = (tag1_kind == KIND_A1 || tag1_kind == KIND_A2) ? y_reg : x_reg;
    assign coef_eff  = coef_vq ? coef_q : '0;
    assign rnd_sum   = 64'(prod_reg) + 64'sd8;
    assign rnd_shift = rnd_sum >>> 4;
    assign zq_eff    = dly_vq ? dly_q : '0;
    assign sum_b0    = 64'(pr_reg) + 64'(zq_eff);
    assign sum_a     = ((tag3_kind == KIND_A1) ? 64'(n1_reg) : 64'(n2_reg)) - 64'(pr_reg);
    assign dly_wdata = sat48(sum_a);
    assign ysum      = (64'(yf_reg) + 64'sd8388608) >>> 24;

    always_comb begin
        clip_ev = ystep_reg && ovf24(ysum);
        case (tag3_kind)
            KIND_B0: clip_ev = clip_ev || pr_ovf_reg || ovf48(sum_b0);
            KIND_B1, KIND_B2: clip_ev = clip_ev || pr_ovf_reg;
            KIND_A1, KIND_A2: clip_ev = clip_ev || pr_ovf_reg || ovf48(sum_a);
            default: clip_ev = clip_ev;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_stages_reg <= '0;
            coef_vld_reg   <= '0;
            dly_vld_reg    <= '0;
            sec_reg        <= '0;
            stp_reg        <= '0;
            iss_done_reg   <= 1'b1;
            tag1_kind      <= KIND_NOP;
            tag2_kind      <= KIND_NOP;
            tag3_kind      <= KIND_NOP;
            ystep_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                num_stages_reg <= cfg_wdata;
            end
            if (coef_we) begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (in_acc && in_func == FUNC_CLEAR) begin
                dly_vld_reg <= '0;
            end else if (dly_we) begin
                dly_vld_reg[dly_waddr] <= 1'b1;
            end
            if (in_acc) begin
                sec_reg      <= '0;
                stp_reg      <= '0;
                iss_done_reg <= 1'b0;
            end else if (iss_act) begin
                if (stp_reg == 3'd5) begin
                    stp_reg <= '0;
                    if (sec_last) begin
                        iss_done_reg <= 1'b1;
                    end else begin
                        sec_reg <= sec_reg + SEC_W'(1);
                    end
                end else begin
                    stp_reg <= stp_reg + 3'd1;
                end
            end
            tag1_kind <= iss_act ? iss_kind : KIND_NOP;
            tag2_kind <= tag1_kind;
            tag3_kind <= tag2_kind;
            ystep_reg <= (tag3_kind == KIND_B0);
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= in_cval;
        end
        coef_q  <= coef_mem[coef_raddr];
        coef_vq <= coef_vld_reg[coef_raddr];
        if (dly_we) begin
            dly_mem[dly_waddr] <= dly_wdata;
        end
        dly_q  <= dly_mem[dly_raddr];
        dly_vq <= dly_vld_reg[dly_raddr];
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        tag1_sec  <= sec_reg;
        tag1_last <= sec_last;
        tag2_sec  <= tag1_sec;
        tag2_last <= tag1_last;
        tag3_sec  <= tag2_sec;
        tag3_last <= tag2_last;

        prod_reg   <= coef_eff * opnd;
        pr_reg     <= sat48(rnd_shift);
        pr_ovf_reg <= ovf48(rnd_shift);

        case (tag3_kind)
            KIND_B0: yf_reg <= sat48(sum_b0);
            KIND_B1: n1_reg <= 50'(pr_reg) + 50'(zq_eff);
            KIND_B2: n2_reg <= 50'(pr_reg);
            default: n2_reg <= n2_reg;
        endcase

        if (in_acc) begin
            x_reg    <= in_sample;
            y_reg    <= in_sample;
            clip_reg <= 1'b0;
        end else begin
            if (tag1_kind == KIND_A2) begin
                x_reg <= y_reg;
            end
            if (ystep_reg) begin
                y_reg <= sat24(ysum);
            end
            clip_reg <= clip_reg || clip_ev;
        end

        if (out_load) begin
            m_tdata_reg <= y_reg;
            m_tuser_reg <= clip_reg;
        end
    end

    assign s_tready   = s_tready_w;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> tag1_kind == KIND_NOP && tag2_kind == KIND_NOP
                                  && tag3_kind == KIND_NOP)
        else $error("Coefficient pipeline busy while idle");

    a_wb_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        dly_we |-> state_reg == ST_RUN)
        else $error("Delay write-back outside a filter run");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("Output beat raised without a finished result");

endmodule
